// File: rtl/mirrored_code_pixel_decoder_defines.svh
// Assertion macros used by the checker file rtl/mcpd_checker.sv of the pixel decoder.
`ifndef MIRRORED_CODE_PIXEL_DECODER_DEFINES_SVH
`define MIRRORED_CODE_PIXEL_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define MCPD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mcpd assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define MCPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mcpd assertion failed");

`endif

// File: rtl/mcpd_pkg.sv
// Shared types and constants of the mirrored-code pixel decoder.
`default_nettype none

package mcpd_pkg;

   // Field widths
   localparam int MASK_W      = 8;
   localparam int CODE_THR_W  = 6;
   localparam int SPAN_W      = 16;
   localparam int OFFSET_W    = 16;
   localparam int CODE_GRP_W  = 48;
   localparam int CODE_EXT_W  = 64;
   localparam int CODE_CMP_W  = 8;
   localparam int FRAC_W      = 8;
   localparam int PROD_W      = FRAC_W + SPAN_W;
   localparam int COORD_W     = 18;
   localparam int PIX_W       = 7;
   localparam int NUM_GROUPS  = 6;

   // Register port
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_KEEP_LEVEL     = 8'd0;
   localparam csr_index_type CSR_CODE_THRESHOLD = 8'd1;
   localparam csr_index_type CSR_X_SPAN         = 8'd2;
   localparam csr_index_type CSR_Y_SPAN         = 8'd3;
   localparam csr_index_type CSR_Z_SPAN         = 8'd4;
   localparam csr_index_type CSR_X_OFFSET       = 8'd5;
   localparam csr_index_type CSR_Y_OFFSET       = 8'd6;
   localparam csr_index_type CSR_Z_OFFSET       = 8'd7;

   // Reset values
   localparam logic [MASK_W-1:0]     MASK_THR_RESET = 8'd128;
   localparam logic [CODE_THR_W-1:0] CODE_THR_RESET = 6'd32;
   localparam logic [SPAN_W-1:0]     SPAN_RESET     = 16'd16;
   localparam logic [OFFSET_W-1:0]   OFFSET_RESET   = 16'd0;

   // Configuration bundle from the register block to the datapath
   typedef struct packed {
      logic [MASK_W-1:0]     keep_level;
      logic [CODE_THR_W-1:0] code_threshold;
      logic [SPAN_W-1:0]     x_span;
      logic [SPAN_W-1:0]     y_span;
      logic [SPAN_W-1:0]     z_span;
      logic [OFFSET_W-1:0]   x_offset;
      logic [OFFSET_W-1:0]   y_offset;
      logic [OFFSET_W-1:0]   z_offset;
   } cfg_type;

endpackage

`default_nettype wire

// File: rtl/mcpd_csr.sv
// Configuration registers of the pixel decoder.
`default_nettype none

module mcpd_csr
   import mcpd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Always able to take a write
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the write; indexes beyond the list leave everything alone
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_KEEP_LEVEL:     cfg_in.keep_level     = csr_data[MASK_W-1:0];
            CSR_CODE_THRESHOLD: cfg_in.code_threshold = csr_data[CODE_THR_W-1:0];
            CSR_X_SPAN:         cfg_in.x_span         = csr_data[SPAN_W-1:0];
            CSR_Y_SPAN:         cfg_in.y_span         = csr_data[SPAN_W-1:0];
            CSR_Z_SPAN:         cfg_in.z_span         = csr_data[SPAN_W-1:0];
            CSR_X_OFFSET:       cfg_in.x_offset       = csr_data[OFFSET_W-1:0];
            CSR_Y_OFFSET:       cfg_in.y_offset       = csr_data[OFFSET_W-1:0];
            CSR_Z_OFFSET:       cfg_in.z_offset       = csr_data[OFFSET_W-1:0];
            default:            cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.keep_level     <= MASK_THR_RESET;
         cfg_ff.code_threshold <= CODE_THR_RESET;
         cfg_ff.x_span         <= SPAN_RESET;
         cfg_ff.y_span         <= SPAN_RESET;
         cfg_ff.z_span         <= SPAN_RESET;
         cfg_ff.x_offset       <= OFFSET_RESET;
         cfg_ff.y_offset       <= OFFSET_RESET;
         cfg_ff.z_offset       <= OFFSET_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/mcpd_coord.sv
// One coordinate: binarize codes, Gray-decode to a fraction, scale and offset.
`default_nettype none

module mcpd_coord
   import mcpd_pkg::*;
#(
   parameter int LEVELS    = 8,
   parameter int CODE_BITS = 6
)
(
   input  wire logic [CODE_GRP_W-1:0] codes,
   input  wire logic [CODE_THR_W-1:0] code_threshold,
   input  wire logic [SPAN_W-1:0]     span,
   input  wire logic [OFFSET_W-1:0]   offset,
   output logic signed [COORD_W-1:0]  coord
);

   logic [CODE_EXT_W-1:0] codes_ext;
   logic [FRAC_W-1:0]     frac;
   logic                  run;
   logic [PROD_W-1:0]     prod;
   logic [SPAN_W-1:0]     scaled;

   // Threshold each level and run the XOR chain; level one lands in the MSB
   always_comb begin
      codes_ext = CODE_EXT_W'(codes);
      run       = 1'b0;
      frac      = '0;
      for (int i = 0; i < LEVELS; i++) begin
         run = run ^ (CODE_CMP_W'(codes_ext[i*CODE_BITS +: CODE_BITS])
                      > CODE_CMP_W'(code_threshold));
         frac[FRAC_W-1-i] = run;
      end
   end

   // Truncated product, then signed offset
   assign prod   = PROD_W'(frac) * PROD_W'(span);
   assign scaled = prod[PROD_W-1:FRAC_W];
   assign coord  = signed'({2'b00, scaled})
                 + signed'({{(COORD_W-OFFSET_W){offset[OFFSET_W-1]}}, offset});

endmodule

`default_nettype wire

// File: rtl/mirrored_code_pixel_decoder.sv
// A kept pixel passes the input register, then the result register, to reach rsp_*.
// Throughput: one pixel per cycle while req_stall is low; the input register
// and the result register together let a new pixel enter while a finished
// result waits on rsp_stall. Masked pixels give no result but still advance
// the column and row counters. Synchronous reset empties both registers,
// zeroes the counters and loads the configuration defaults.
`default_nettype none

module mirrored_code_pixel_decoder
   import mcpd_pkg::*;
#(
   parameter int FRAME_WIDTH  = 128,
   parameter int FRAME_HEIGHT = 128,
   parameter int LEVELS       = 8,
   parameter int CODE_BITS    = 6
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // pixel input
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [MASK_W-1:0]      req_mask_value,
   input  wire logic [CODE_GRP_W-1:0]  req_front_x_codes,
   input  wire logic [CODE_GRP_W-1:0]  req_front_y_codes,
   input  wire logic [CODE_GRP_W-1:0]  req_front_z_codes,
   input  wire logic [CODE_GRP_W-1:0]  req_back_x_codes,
   input  wire logic [CODE_GRP_W-1:0]  req_back_y_codes,
   input  wire logic [CODE_GRP_W-1:0]  req_back_z_codes,
   // result output
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [PIX_W-1:0]            rsp_pixel_col,
   output logic [PIX_W-1:0]            rsp_pixel_row,
   output logic signed [COORD_W-1:0]   rsp_front_x,
   output logic signed [COORD_W-1:0]   rsp_front_y,
   output logic signed [COORD_W-1:0]   rsp_front_z,
   output logic signed [COORD_W-1:0]   rsp_back_x,
   output logic signed [COORD_W-1:0]   rsp_back_y,
   output logic signed [COORD_W-1:0]   rsp_back_z,
   // register writes
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int COL_W = (FRAME_WIDTH  > 1) ? $clog2(FRAME_WIDTH)  : 1;
   localparam int ROW_W = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;

   cfg_type cfg;

   logic [COL_W-1:0] col_count_ff, col_count_in;
   logic [ROW_W-1:0] row_count_ff, row_count_in;

   logic                  s0_valid_ff, s0_valid_in;
   logic [CODE_GRP_W-1:0] s0_codes_ff [NUM_GROUPS];
   logic [PIX_W-1:0]      s0_col_ff;
   logic [PIX_W-1:0]      s0_row_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]          rsp_col_ff;
   logic [PIX_W-1:0]          rsp_row_ff;
   logic signed [COORD_W-1:0] rsp_coord_ff [NUM_GROUPS];
   logic signed [COORD_W-1:0] coord        [NUM_GROUPS];

   logic req_accept;
   logic keep;
   logic out_free;
   logic s0_move;

   mcpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Flow control: input register feeds result register
   assign out_free    = ~rsp_valid_ff | ~rsp_stall;
   assign s0_move     = s0_valid_ff & out_free;
   assign req_stall   = s0_valid_ff & ~out_free;
   assign req_accept  = req_valid & ~req_stall;
   assign keep        = req_mask_value > cfg.keep_level;
   assign s0_valid_in = (req_accept & keep) | (s0_valid_ff & ~out_free);
   assign rsp_valid_in = s0_move | (rsp_valid_ff & rsp_stall);

   // Raster counters advance on every accepted pixel
   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (req_accept) begin
         if (col_count_ff == COL_W'(FRAME_WIDTH - 1)) begin
            col_count_in = '0;
            if (row_count_ff == ROW_W'(FRAME_HEIGHT - 1)) begin
               row_count_in = '0;
            end else begin
               row_count_in = row_count_ff + 1'b1;
            end
         end else begin
            col_count_in = col_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
      end
   end

   // Input register payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s0_codes_ff[0] <= req_front_x_codes;
         s0_codes_ff[1] <= req_front_y_codes;
         s0_codes_ff[2] <= req_front_z_codes;
         s0_codes_ff[3] <= req_back_x_codes;
         s0_codes_ff[4] <= req_back_y_codes;
         s0_codes_ff[5] <= req_back_z_codes;
         s0_col_ff      <= PIX_W'(col_count_ff);
         s0_row_ff      <= PIX_W'(row_count_ff);
      end
   end

   // Coordinate datapath, front x y z then back x y z
   mcpd_coord #(.LEVELS(LEVELS), .CODE_BITS(CODE_BITS)) u_front_x (
      .codes (s0_codes_ff[0]), .code_threshold (cfg.code_threshold),
      .span  (cfg.x_span),     .offset (cfg.x_offset), .coord (coord[0])
   );
   mcpd_coord #(.LEVELS(LEVELS), .CODE_BITS(CODE_BITS)) u_front_y (
      .codes (s0_codes_ff[1]), .code_threshold (cfg.code_threshold),
      .span  (cfg.y_span),     .offset (cfg.y_offset), .coord (coord[1])
   );
   mcpd_coord #(.LEVELS(LEVELS), .CODE_BITS(CODE_BITS)) u_front_z (
      .codes (s0_codes_ff[2]), .code_threshold (cfg.code_threshold),
      .span  (cfg.z_span),     .offset (cfg.z_offset), .coord (coord[2])
   );
   mcpd_coord #(.LEVELS(LEVELS), .CODE_BITS(CODE_BITS)) u_back_x (
      .codes (s0_codes_ff[3]), .code_threshold (cfg.code_threshold),
      .span  (cfg.x_span),     .offset (cfg.x_offset), .coord (coord[3])
   );
   mcpd_coord #(.LEVELS(LEVELS), .CODE_BITS(CODE_BITS)) u_back_y (
      .codes (s0_codes_ff[4]), .code_threshold (cfg.code_threshold),
      .span  (cfg.y_span),     .offset (cfg.y_offset), .coord (coord[4])
   );
   mcpd_coord #(.LEVELS(LEVELS), .CODE_BITS(CODE_BITS)) u_back_z (
      .codes (s0_codes_ff[5]), .code_threshold (cfg.code_threshold),
      .span  (cfg.z_span),     .offset (cfg.z_offset), .coord (coord[5])
   );

   // Result register payload
   always_ff @(posedge clock) begin
      if (s0_move) begin
         rsp_col_ff <= s0_col_ff;
         rsp_row_ff <= s0_row_ff;
         for (int g = 0; g < NUM_GROUPS; g++) begin
            rsp_coord_ff[g] <= coord[g];
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_col = rsp_col_ff;
   assign rsp_pixel_row = rsp_row_ff;
   assign rsp_front_x   = rsp_coord_ff[0];
   assign rsp_front_y   = rsp_coord_ff[1];
   assign rsp_front_z   = rsp_coord_ff[2];
   assign rsp_back_x    = rsp_coord_ff[3];
   assign rsp_back_y    = rsp_coord_ff[4];
   assign rsp_back_z    = rsp_coord_ff[5];

endmodule

`default_nettype wire

// File: rtl/mcpd_checker.sv
// Port-level checks of the pixel decoder and their binding to the top level.
`default_nettype none
`include "mirrored_code_pixel_decoder_defines.svh"

module mcpd_checker
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_stall,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire logic                   csr_valid,
   input wire logic                   csr_ready
);

   // A stalled result stays offered
   `MCPD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // Input only backs up when a result is stuck at the output
   `MCPD_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // Register writes are never refused
   `MCPD_ASSERT_NOW(a_csr_ready, clock, reset, csr_valid || !csr_valid, csr_ready)

   // Pipeline comes out of reset empty
   `MCPD_ASSERT_NOW(a_reset_empty, clock, reset, $past(reset), !rsp_valid)

endmodule

bind mirrored_code_pixel_decoder mcpd_checker u_mcpd_checker (.*);

`default_nettype wire

// File: bench/mcpd_checker.sv
`timescale 1ns / 1ps
// Checker for the pixel decoder: tracks settings, predicts each kept pixel, compares results.
module mcpd_bench_checker
   import mcpd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_stall,
   input  wire logic [MASK_W-1:0]      req_mask_value,
   input  wire logic [CODE_GRP_W-1:0]  req_front_x_codes,
   input  wire logic [CODE_GRP_W-1:0]  req_front_y_codes,
   input  wire logic [CODE_GRP_W-1:0]  req_front_z_codes,
   input  wire logic [CODE_GRP_W-1:0]  req_back_x_codes,
   input  wire logic [CODE_GRP_W-1:0]  req_back_y_codes,
   input  wire logic [CODE_GRP_W-1:0]  req_back_z_codes,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire logic [PIX_W-1:0]       rsp_pixel_col,
   input  wire logic [PIX_W-1:0]       rsp_pixel_row,
   input  wire logic [COORD_W-1:0]     rsp_front_x,
   input  wire logic [COORD_W-1:0]     rsp_front_y,
   input  wire logic [COORD_W-1:0]     rsp_front_z,
   input  wire logic [COORD_W-1:0]     rsp_back_x,
   input  wire logic [COORD_W-1:0]     rsp_back_y,
   input  wire logic [COORD_W-1:0]     rsp_back_z,
   input  wire logic                   csr_valid,
   input  wire logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output int                          mismatch_count,
   output int                          pending_count
);

   localparam int FRAME_W   = 128;
   localparam int FRAME_H   = 128;
   localparam int LEVELS    = 8;
   localparam int CODE_BITS = 6;
   localparam int MAX_SHOWN = 10;

   // One decoded surface point: pixel position plus front and back coordinates
   typedef struct packed {
      logic [PIX_W-1:0]                      col;
      logic [PIX_W-1:0]                      row;
      logic [NUM_GROUPS-1:0][COORD_W-1:0]    coord;
   } surface_point_type;

   cfg_type           settings;
   int                col_pos;
   int                row_pos;
   surface_point_type points_due[$];

   // Threshold each code, then undo the reflected code by a running XOR
   function automatic logic [FRAC_W-1:0] unmirror(input logic [CODE_GRP_W-1:0] codes,
                                                  input logic [CODE_THR_W-1:0] thr);
      logic [FRAC_W-1:0] frac;
      logic              bit_run;
      frac    = '0;
      bit_run = 1'b0;
      for (int lvl = 0; lvl < LEVELS; lvl++) begin
         bit_run = bit_run ^ (codes[lvl*CODE_BITS +: CODE_BITS] > thr);
         frac[FRAC_W-1-lvl] = bit_run;
      end
      return frac;
   endfunction

   // Scale the fraction by the span (truncated) and add the signed minimum
   function automatic logic [COORD_W-1:0] place(input logic [FRAC_W-1:0]   frac,
                                                input logic [SPAN_W-1:0]   span,
                                                input logic [OFFSET_W-1:0] offset);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(frac) * PROD_W'(span);
      return {{(COORD_W-SPAN_W){1'b0}}, prod[PROD_W-1:FRAC_W]}
           + {{(COORD_W-OFFSET_W){offset[OFFSET_W-1]}}, offset};
   endfunction

   task automatic check_field(input string name, input logic [COORD_W-1:0] want_v,
                              input logic [COORD_W-1:0] got_v, input bit is_coord);
      if (want_v !== got_v) begin
         mismatch_count++;
         if (mismatch_count <= MAX_SHOWN) begin
            if (is_coord)
               $display("%s mismatch: expected %0d, got %0d", name,
                        $signed(want_v), $signed(got_v));
            else
               $display("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
         end
      end
   endtask

   // Register writes, pixel prediction and result comparison, all at the rising edge
   always @(posedge clock) begin : watch
      surface_point_type predicted;
      surface_point_type seen;
      surface_point_type oldest;
      if (reset) begin
         settings.keep_level     = MASK_THR_RESET;
         settings.code_threshold = CODE_THR_RESET;
         settings.x_span         = SPAN_RESET;
         settings.y_span         = SPAN_RESET;
         settings.z_span         = SPAN_RESET;
         settings.x_offset       = OFFSET_RESET;
         settings.y_offset       = OFFSET_RESET;
         settings.z_offset       = OFFSET_RESET;
         col_pos        = 0;
         row_pos        = 0;
         mismatch_count = 0;
         points_due.delete();
      end else begin
         // register transaction; indexes past the list are dropped
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_KEEP_LEVEL:     settings.keep_level     = csr_data[MASK_W-1:0];
               CSR_CODE_THRESHOLD: settings.code_threshold = csr_data[CODE_THR_W-1:0];
               CSR_X_SPAN:         settings.x_span         = csr_data[SPAN_W-1:0];
               CSR_Y_SPAN:         settings.y_span         = csr_data[SPAN_W-1:0];
               CSR_Z_SPAN:         settings.z_span         = csr_data[SPAN_W-1:0];
               CSR_X_OFFSET:       settings.x_offset       = csr_data[OFFSET_W-1:0];
               CSR_Y_OFFSET:       settings.y_offset       = csr_data[OFFSET_W-1:0];
               CSR_Z_OFFSET:       settings.z_offset       = csr_data[OFFSET_W-1:0];
               default: ;
            endcase
         end

         // pixel transaction: predict only when the mask is strictly above threshold
         if (req_valid && !req_stall) begin
            if (req_mask_value > settings.keep_level) begin
               predicted.col      = col_pos[PIX_W-1:0];
               predicted.row      = row_pos[PIX_W-1:0];
               predicted.coord[0] = place(unmirror(req_front_x_codes, settings.code_threshold),
                                          settings.x_span, settings.x_offset);
               predicted.coord[1] = place(unmirror(req_front_y_codes, settings.code_threshold),
                                          settings.y_span, settings.y_offset);
               predicted.coord[2] = place(unmirror(req_front_z_codes, settings.code_threshold),
                                          settings.z_span, settings.z_offset);
               predicted.coord[3] = place(unmirror(req_back_x_codes, settings.code_threshold),
                                          settings.x_span, settings.x_offset);
               predicted.coord[4] = place(unmirror(req_back_y_codes, settings.code_threshold),
                                          settings.y_span, settings.y_offset);
               predicted.coord[5] = place(unmirror(req_back_z_codes, settings.code_threshold),
                                          settings.z_span, settings.z_offset);
               points_due.insert(points_due.size(), predicted);
            end
            // raster position moves on for every pixel, kept or not
            col_pos++;
            if (col_pos == FRAME_W) begin
               col_pos = 0;
               row_pos++;
               if (row_pos == FRAME_H)
                  row_pos = 0;
            end
         end

         // result transaction
         if (rsp_valid && !rsp_stall) begin
            seen.col      = rsp_pixel_col;
            seen.row      = rsp_pixel_row;
            seen.coord[0] = rsp_front_x;
            seen.coord[1] = rsp_front_y;
            seen.coord[2] = rsp_front_z;
            seen.coord[3] = rsp_back_x;
            seen.coord[4] = rsp_back_y;
            seen.coord[5] = rsp_back_z;
            if (points_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_SHOWN)
                  $display("result at col %0d row %0d with no pixel pending",
                           seen.col, seen.row);
            end else begin
               oldest = points_due.pop_front();
               check_field("pixel_col", {{(COORD_W-PIX_W){1'b0}}, oldest.col},
                           {{(COORD_W-PIX_W){1'b0}}, seen.col}, 1'b0);
               check_field("pixel_row", {{(COORD_W-PIX_W){1'b0}}, oldest.row},
                           {{(COORD_W-PIX_W){1'b0}}, seen.row}, 1'b0);
               check_field("front_x", oldest.coord[0], seen.coord[0], 1'b1);
               check_field("front_y", oldest.coord[1], seen.coord[1], 1'b1);
               check_field("front_z", oldest.coord[2], seen.coord[2], 1'b1);
               check_field("back_x",  oldest.coord[3], seen.coord[3], 1'b1);
               check_field("back_y",  oldest.coord[4], seen.coord[4], 1'b1);
               check_field("back_z",  oldest.coord[5], seen.coord[5], 1'b1);
            end
         end
      end
      pending_count = points_due.size();
   end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Bench top for the pixel decoder: clock, reset, stimulus, receiver stalls and verdict.
module tb_top
   import mcpd_pkg::*;
();

   localparam int CYCLE_LIMIT     = 500000;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int RANDOM_PHASES   = 12;
   localparam int PHASE_PIXELS    = 110;
   localparam int BURST_PIXELS    = 40;
   localparam int DRAIN_CYCLES    = 8;
   localparam int HOLD_PHASE      = 2;

   // register indexes outside the decoder's list
   localparam csr_index_type CSR_FIRST_UNUSED = 8'd8;
   localparam csr_index_type CSR_TOP_INDEX    = 8'hFF;

   // level one only, and level eight only, set to full scale
   localparam logic [CODE_GRP_W-1:0] LEVEL_ONE_ONLY   = 48'h0000_0000_003F;
   localparam logic [CODE_GRP_W-1:0] LEVEL_EIGHT_ONLY = 48'hFC00_0000_0000;

   typedef struct packed {
      logic [MASK_W-1:0]                      mask;
      logic [NUM_GROUPS-1:0][CODE_GRP_W-1:0]  codes;
   } pixel_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [MASK_W-1:0]      req_mask_value = '0;
   logic [CODE_GRP_W-1:0]  req_front_x_codes = '0;
   logic [CODE_GRP_W-1:0]  req_front_y_codes = '0;
   logic [CODE_GRP_W-1:0]  req_front_z_codes = '0;
   logic [CODE_GRP_W-1:0]  req_back_x_codes = '0;
   logic [CODE_GRP_W-1:0]  req_back_y_codes = '0;
   logic [CODE_GRP_W-1:0]  req_back_z_codes = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [PIX_W-1:0]       rsp_pixel_col;
   logic [PIX_W-1:0]       rsp_pixel_row;
   logic [COORD_W-1:0]     rsp_front_x;
   logic [COORD_W-1:0]     rsp_front_y;
   logic [COORD_W-1:0]     rsp_front_z;
   logic [COORD_W-1:0]     rsp_back_x;
   logic [COORD_W-1:0]     rsp_back_y;
   logic [COORD_W-1:0]     rsp_back_z;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;
   int                     mismatch_count;
   int                     pending_count;

   // stimulus-side view of the thresholds, only used to shape pixels
   logic [MASK_W-1:0]      mask_thr_now = MASK_THR_RESET;
   logic [CODE_THR_W-1:0]  code_thr_now = CODE_THR_RESET;

   int  cycle_count = 0;
   int  hold_asks = 0;
   int  hold_done = 0;
   int  send_mode_left = 0;
   bit  send_quiet = 1'b0;
   int  recv_mode_left = 0;
   bit  recv_quiet = 1'b0;

   mirrored_code_pixel_decoder dut (.*);

   mcpd_bench_checker u_checker (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run-away guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // idle gaps come in stretches: some with random gaps, some back to back
   function automatic int sender_gap();
      if (send_mode_left == 0) begin
         send_quiet     = ($urandom_range(0, 3) == 0);
         send_mode_left = $urandom_range(20, 80);
      end
      send_mode_left--;
      return send_quiet ? 0 : $urandom_range(0, 15);
   endfunction

   function automatic int receiver_wait();
      if (recv_mode_left == 0) begin
         recv_quiet     = ($urandom_range(0, 3) == 0);
         recv_mode_left = $urandom_range(10, 50);
      end
      recv_mode_left--;
      return recv_quiet ? 0 : $urandom_range(0, 15);
   endfunction

   // codes cluster around the threshold and the extremes
   function automatic logic [CODE_GRP_W-1:0] random_group();
      logic [CODE_GRP_W-1:0] grp;
      logic [CODE_THR_W-1:0] code;
      grp = '0;
      for (int lvl = 0; lvl < 8; lvl++) begin
         case ($urandom_range(0, 5))
            0: code = code_thr_now;
            1: code = (code_thr_now == 6'd63) ? code_thr_now : code_thr_now + 6'd1;
            2: code = 6'd0;
            3: code = 6'd63;
            default: code = 6'($urandom_range(0, 63));
         endcase
         grp[lvl*6 +: 6] = code;
      end
      return grp;
   endfunction

   function automatic logic [MASK_W-1:0] kept_mask();
      return (mask_thr_now == 8'hFF) ? 8'hFF
                                     : 8'($urandom_range(int'(mask_thr_now) + 1, 255));
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type px;
      case ($urandom_range(0, 9))
         0: px.mask = mask_thr_now;
         1: px.mask = 8'($urandom_range(0, int'(mask_thr_now)));
         2: px.mask = 8'($urandom_range(0, 255));
         default: px.mask = kept_mask();
      endcase
      for (int g = 0; g < NUM_GROUPS; g++)
         px.codes[g] = random_group();
      return px;
   endfunction

   function automatic pixel_type uniform_pixel(input logic [MASK_W-1:0] mask,
                                               input logic [CODE_THR_W-1:0] code);
      pixel_type px;
      px.mask = mask;
      for (int g = 0; g < NUM_GROUPS; g++)
         px.codes[g] = {8{code}};
      return px;
   endfunction

   function automatic pixel_type pattern_pixel(input logic [MASK_W-1:0] mask,
                                               input logic [CODE_GRP_W-1:0] grp);
      pixel_type px;
      px.mask = mask;
      for (int g = 0; g < NUM_GROUPS; g++)
         px.codes[g] = grp;
      return px;
   endfunction

   // one pixel transaction, after an idle gap
   task automatic send_pixel(input pixel_type px, input int gap);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_mask_value    <= px.mask;
      req_front_x_codes <= px.codes[0];
      req_front_y_codes <= px.codes[1];
      req_front_z_codes <= px.codes[2];
      req_back_x_codes  <= px.codes[3];
      req_back_y_codes  <= px.codes[4];
      req_back_z_codes  <= px.codes[5];
      req_valid         <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_KEEP_LEVEL)
         mask_thr_now = data[MASK_W-1:0];
      if (idx == CSR_CODE_THRESHOLD)
         code_thr_now = data[CODE_THR_W-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // stop offering, let every kept pixel come out, then cover masked ones in flight
   task automatic go_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [SPAN_W-1:0] random_span();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [OFFSET_W-1:0] random_offset();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic random_settings();
      case ($urandom_range(0, 7))
         0: write_reg(CSR_KEEP_LEVEL, 16'd0);
         default: write_reg(CSR_KEEP_LEVEL, 16'($urandom_range(0, 254)));
      endcase
      case ($urandom_range(0, 7))
         0: write_reg(CSR_CODE_THRESHOLD, 16'd0);
         1: write_reg(CSR_CODE_THRESHOLD, 16'd63);
         default: write_reg(CSR_CODE_THRESHOLD, 16'($urandom_range(0, 63)));
      endcase
      write_reg(CSR_X_SPAN, random_span());
      write_reg(CSR_Y_SPAN, random_span());
      write_reg(CSR_Z_SPAN, random_span());
      write_reg(CSR_X_OFFSET, random_offset());
      write_reg(CSR_Y_OFFSET, random_offset());
      write_reg(CSR_Z_OFFSET, random_offset());
   endtask

   // receiver: a random wait per result, plus a long hold-off on request
   initial begin : receiver
      int wait_n;
      forever begin
         @(negedge clock);
         if (hold_asks != hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_done++;
            rsp_stall <= 1'b0;
         end else if (rsp_valid) begin
            wait_n = receiver_wait();
            if (wait_n > 0) begin
               rsp_stall <= 1'b1;
               repeat (wait_n) @(negedge clock);
            end
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      pixel_type px;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: mask extremes, mask equal to threshold, code extremes
      send_pixel(uniform_pixel(8'd0, 6'd0), 0);
      send_pixel(uniform_pixel(8'd128, 6'd63), 0);
      send_pixel(uniform_pixel(8'd129, 6'd0), 0);
      send_pixel(uniform_pixel(8'd255, 6'd63), 0);
      send_pixel(uniform_pixel(8'd255, 6'd33), 1);
      send_pixel(uniform_pixel(8'd200, 6'd32), 0);
      send_pixel(pattern_pixel(8'd255, LEVEL_ONE_ONLY), 2);
      send_pixel(pattern_pixel(8'd255, LEVEL_EIGHT_ONLY), 0);
      repeat (4) send_pixel(random_pixel(), sender_gap());
      go_idle();

      // top of span and offset range; upper data bits of narrow registers are cut off
      write_reg(CSR_KEEP_LEVEL, 16'hA500);
      write_reg(CSR_CODE_THRESHOLD, 16'hFFC0);
      write_reg(CSR_X_SPAN, 16'hFFFF);
      write_reg(CSR_Y_SPAN, 16'hFFFF);
      write_reg(CSR_Z_SPAN, 16'hFFFF);
      write_reg(CSR_X_OFFSET, 16'h7FFF);
      write_reg(CSR_Y_OFFSET, 16'h7FFF);
      write_reg(CSR_Z_OFFSET, 16'h7FFF);
      write_reg(CSR_FIRST_UNUSED, 16'hFFFF);
      write_reg(CSR_TOP_INDEX, 16'h1234);
      send_pixel(uniform_pixel(8'd0, 6'd63), 0);
      send_pixel(uniform_pixel(8'd1, 6'd1), 0);
      send_pixel(uniform_pixel(8'd255, 6'd0), 3);
      send_pixel(pattern_pixel(8'd255, LEVEL_ONE_ONLY), 0);
      send_pixel(random_pixel(), 0);
      go_idle();

      // bottom of range: nothing binarizes, zero span, most negative offset
      write_reg(CSR_KEEP_LEVEL, 16'd254);
      write_reg(CSR_CODE_THRESHOLD, 16'd63);
      write_reg(CSR_X_SPAN, 16'd0);
      write_reg(CSR_Y_SPAN, 16'd0);
      write_reg(CSR_Z_SPAN, 16'd0);
      write_reg(CSR_X_OFFSET, 16'h8000);
      write_reg(CSR_Y_OFFSET, 16'h8000);
      write_reg(CSR_Z_OFFSET, 16'h8000);
      send_pixel(uniform_pixel(8'd254, 6'd63), 0);
      send_pixel(uniform_pixel(8'd255, 6'd63), 0);
      send_pixel(uniform_pixel(8'd255, 6'd0), 0);

      // random phases, each under fresh settings
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         go_idle();
         random_settings();
         if (ph == HOLD_PHASE) begin
            // receiver holds off while kept pixels arrive back to back
            hold_asks++;
            repeat (BURST_PIXELS) begin
               px      = random_pixel();
               px.mask = kept_mask();
               send_pixel(px, 0);
            end
         end
         repeat (PHASE_PIXELS) send_pixel(random_pixel(), sender_gap());
      end

      go_idle();
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: mirrored_code_pixel_decoder.f
+incdir+rtl
rtl/mcpd_pkg.sv
rtl/mcpd_csr.sv
rtl/mcpd_coord.sv
rtl/mirrored_code_pixel_decoder.sv
rtl/mcpd_checker.sv
bench/mcpd_checker.sv
bench/tb_top.sv
